/* sv/lis_max_segment_tree_defines.svh */
// ----------------------------------------------------------------------------
// lis_max_segment_tree assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LIS_MAX_SEGMENT_TREE_DEFINES_SVH
`define LIS_MAX_SEGMENT_TREE_DEFINES_SVH

// same-cycle implication
`define LMS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lms assertion failed");

// next-cycle implication
`define LMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lms assertion failed");

`endif

/* sv/lms_pkg.sv */
// ----------------------------------------------------------------------------
// lms_pkg
// types, constants and helpers shared by the segment tree sequencer and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lms_pkg;

   localparam int RANK_W    = 10;
   localparam int LEN_W     = 11;
   localparam int RANKS_DEF = 1024;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_CALC,
      ST_UPDATE,
      ST_BEST,
      ST_RESP
   } lms_state_type;

   // one-hot step commands from the sequencer
   typedef struct packed {
      logic clr;
      logic load;
      logic qry;
      logic calc;
      logic upd;
      logic best;
   } lms_ctrl_type;

   // walk status back to the sequencer
   typedef struct packed {
      logic clr_last;
      logic qry_last;
      logic upd_last;
   } lms_status_type;

   function automatic logic [LEN_W-1:0] len_max(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* sv/lms_seq.sv */
// ----------------------------------------------------------------------------
// lms_seq
// sequencer: clear pass, query walk, length calc, update walk, best, response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lms_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  lms_pkg::lms_status_type status,
   output lms_pkg::lms_ctrl_type   ctrl
);
   import lms_pkg::*;

   lms_state_type state_ff;
   lms_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_QUERY;
            end
         end
         ST_QUERY: begin
            ctrl.qry = 1'b1;
            if (status.qry_last) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            ctrl.calc = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctrl.upd = 1'b1;
            if (status.upd_last) begin
               state_in = ST_BEST;
            end
         end
         ST_BEST: begin
            ctrl.best = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

/* sv/lms_path.sv */
// ----------------------------------------------------------------------------
// lms_path
// tree memory, node walker and the shared max unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lis_max_segment_tree_defines.svh"

module lms_path #(
   parameter int RANKS = lms_pkg::RANKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lms_pkg::lms_ctrl_type       ctrl,
   output lms_pkg::lms_status_type     status,
   input  logic [lms_pkg::RANK_W-1:0]  req_rank,
   output logic [lms_pkg::LEN_W-1:0]   rsp_length_here,
   output logic [lms_pkg::LEN_W-1:0]   rsp_best_length
);
   import lms_pkg::*;

   localparam int LEAF_BITS = $clog2(RANKS);
   localparam int ADDR_W    = LEAF_BITS + 1;
   localparam int DEPTH     = 2 ** ADDR_W;
   localparam logic [31:0] RANKS_U = 32'(RANKS);

   // tree memory, heap ordered, root at 1
   logic [LEN_W-1:0] mem [0:DEPTH-1];
   logic [LEN_W-1:0] q_ff;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LEN_W-1:0]  wr_data;

   logic [ADDR_W-1:0] node_ff,  node_in;
   logic [ADDR_W-1:0] leaf_ff,  leaf_in;
   logic [ADDR_W-1:0] wnode_ff, wnode_in;
   logic [ADDR_W-1:0] clr_ff,   clr_in;
   logic              pend_ff,  pend_in;
   logic              take_ff,  take_in;
   logic [LEN_W-1:0]  below_ff, below_in;
   logic [LEN_W-1:0]  len_ff,   len_in;
   logic [LEN_W-1:0]  best_ff,  best_in;

   logic [31:0]       raw32;
   logic [31:0]       rank32;
   logic [LEN_W-1:0]  op_a;
   logic [LEN_W-1:0]  op_b;
   logic [LEN_W-1:0]  max_out;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   // shared max unit
   assign op_a    = (ctrl.upd || ctrl.best) ? len_ff : below_ff;
   assign op_b    = ctrl.best ? best_ff : q_ff;
   assign max_out = len_max(op_a, op_b);

   // out-of-range ranks clamp to the top rank
   assign raw32  = 32'(req_rank);
   assign rank32 = (raw32 >= RANKS_U) ? (RANKS_U - 32'd1) : raw32;

   assign status.clr_last = (clr_ff == {ADDR_W{1'b1}});
   assign status.qry_last = (node_ff == ADDR_W'(1));
   assign status.upd_last = (node_ff == '0);

   always_comb begin
      node_in  = node_ff;
      leaf_in  = leaf_ff;
      wnode_in = wnode_ff;
      clr_in   = clr_ff;
      pend_in  = pend_ff;
      take_in  = take_ff;
      below_in = below_ff;
      len_in   = len_ff;
      best_in  = best_ff;
      rd_en    = 1'b0;
      rd_addr  = node_ff;
      wr_en    = 1'b0;
      wr_addr  = wnode_ff;
      wr_data  = max_out;

      if (ctrl.clr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
         clr_in  = clr_ff + ADDR_W'(1);
      end

      if (ctrl.load) begin
         leaf_in  = {1'b1, rank32[LEAF_BITS-1:0]};
         node_in  = {1'b1, rank32[LEAF_BITS-1:0]};
         below_in = '0;
         pend_in  = 1'b0;
      end

      if (ctrl.qry) begin
         // fold the left sibling read last cycle
         if (pend_ff && take_ff) begin
            below_in = max_out;
         end
         if (|node_ff[ADDR_W-1:1]) begin
            rd_en   = 1'b1;
            rd_addr = {node_ff[ADDR_W-1:1], 1'b0};
            take_in = node_ff[0];
            pend_in = 1'b1;
            node_in = {1'b0, node_ff[ADDR_W-1:1]};
         end else begin
            pend_in = 1'b0;
         end
      end

      if (ctrl.calc) begin
         len_in  = (below_ff == LEN_MAX) ? LEN_MAX : below_ff + LEN_W'(1);
         node_in = leaf_ff;
         pend_in = 1'b0;
      end

      if (ctrl.upd) begin
         // write back the node read last cycle, read the next one up
         if (pend_ff) begin
            wr_en   = 1'b1;
            wr_addr = wnode_ff;
            wr_data = max_out;
         end
         if (node_ff != '0) begin
            rd_en    = 1'b1;
            rd_addr  = node_ff;
            wnode_in = node_ff;
            pend_in  = 1'b1;
            node_in  = {1'b0, node_ff[ADDR_W-1:1]};
         end else begin
            pend_in = 1'b0;
         end
      end

      if (ctrl.best) begin
         best_in = max_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         pend_ff <= 1'b0;
         take_ff <= 1'b0;
         best_ff <= '0;
      end else begin
         clr_ff  <= clr_in;
         pend_ff <= pend_in;
         take_ff <= take_in;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      leaf_ff  <= leaf_in;
      wnode_ff <= wnode_in;
      below_ff <= below_in;
      len_ff   <= len_in;
   end

   assign rsp_length_here = len_ff;
   assign rsp_best_length = best_ff;

   `LMS_ASSERT_IMPLY(a_ctrl_onehot, 1'b1, $onehot0(ctrl))
   `LMS_ASSERT_IMPLY(a_no_write_in_query, ctrl.qry, !wr_en)
   `LMS_ASSERT_NEXT(a_len_nonzero, ctrl.calc, len_ff != '0)
   `LMS_ASSERT_IMPLY(a_upd_write_ge_len, ctrl.upd && wr_en, wr_data >= len_ff)
   `LMS_ASSERT_NEXT(a_best_covers_len, ctrl.best, best_ff >= len_ff)

endmodule

/* sv/lis_max_segment_tree.sv */
// ----------------------------------------------------------------------------
// lis_max_segment_tree
// streaming longest strictly increasing subsequence over dense ranks
// ----------------------------------------------------------------------------
// usage
//   req_valid/req_stall/req_rank: one rank per transfer; ranks at or above
//     RANKS clamp to RANKS-1
//   rsp_valid/rsp_stall/rsp_length_here/rsp_best_length: one result per rank,
//     the length ending at this rank and the running best since reset
//   one item at a time: the max tree memory has a single read and a single
//     write port, walked leaf to root twice by one shared max unit
//   steps: after the req transfer a query walk, a length calc, an update
//     read-modify-write walk and a best step run before rsp_valid rises
//   reset: synchronous; after it a clearing pass zeroes the tree, one entry
//     a cycle over 2^(L+1) entries, with req_stall high; the running best
//     resets to zero
//   a new sequence needs a reset
//   rsp_stall: the result holds on the rsp ports and req_stall stays high
//     until the transfer completes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lis_max_segment_tree #(
   parameter int RANKS = lms_pkg::RANKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lms_pkg::RANK_W-1:0]  req_rank,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lms_pkg::LEN_W-1:0]   rsp_length_here,
   output logic [lms_pkg::LEN_W-1:0]   rsp_best_length
);
   import lms_pkg::*;

   // step commands and walk status between sequencer and datapath
   lms_ctrl_type   ctrl;
   lms_status_type status;

   // sequencer owns both handshakes
   lms_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // tree memory, walker and max unit; result registers hold while stalled
   lms_path #(
      .RANKS (RANKS)
   ) u_path (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_rank        (req_rank),
      .rsp_length_here (rsp_length_here),
      .rsp_best_length (rsp_best_length)
   );

endmodule
